@@ hdl/hsc_pkg.sv @@
`timescale 1ns / 1ps

package hsc_pkg;

    // Function codes of a request.
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Status codes of a result.
    localparam logic [1:0] STAT_CLEAN     = 2'd0;
    localparam logic [1:0] STAT_CORRECTED = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;

    // Configuration register indexes.
    localparam logic REG_DATA_LEN = 1'b0;

    localparam int WORD_W = 64;
    localparam int POS_W  = 6;
    localparam int PAR_W  = 3;

    // Code geometry derived from the data length register.
    typedef struct packed {
        logic [POS_W-1:0] d;  // data bits in use, clamped
        logic [PAR_W-1:0] r;  // parity bits
        logic [POS_W-1:0] n;  // codeword length
    } t_geom;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        status;
        logic [POS_W-1:0]  syn;
    } t_result;

    // Smallest r with 2^r - r >= d + 1, for d in 1..57.
    function automatic logic [PAR_W-1:0] parity_count(input logic [POS_W-1:0] d);
        logic [PAR_W-1:0] r;
        if (d <= 6'd1) begin
            r = 3'd2;
        end else if (d <= 6'd4) begin
            r = 3'd3;
        end else if (d <= 6'd11) begin
            r = 3'd4;
        end else if (d <= 6'd26) begin
            r = 3'd5;
        end else begin
            r = 3'd6;
        end
        return r;
    endfunction

endpackage

@@ hdl/hamming_sec_codec.sv @@
`timescale 1ns / 1ps
// Hamming single-error-correcting encoder and decoder.
// Requests enter on i_in_valid / o_in_stall with i_func (0 encode, 1 decode)
// and i_word_in; results leave on o_out_valid / i_out_stall. A request is
// taken at a clock edge where its valid is high and its stall is low.
// Encoding turns the low data_len bits of i_word_in into a codeword; decoding
// takes a codeword, corrects the bit named by the syndrome if it lies inside the codeword and returns the data.
// The data length register sits at APB byte address 0 and may only be written
// while no request is in flight.
// o_out_valid rises once a request has passed the input register and the
// result register: the input register feeds the XOR trees of the codec, which
// feed the result register, and a full, stalled result register holds it back.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single pass through the codec logic between the two register stages.
// If the receiver stalls, the result register holds and the input register
// still takes one more request; o_in_stall rises only when both are full.
// Synchronous reset empties both stages and sets the data length to 4.
module hamming_sec_codec #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [63:0] i_word_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_word_out,
    output logic [1:0]  o_status,
    output logic [5:0]  o_error_position,
    output logic [2:0]  o_parity_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hsc_pkg::t_geom   w_geom;
    hsc_pkg::t_result w_result;

    logic        r_s1_vld;
    logic        r_s1_func;
    logic [63:0] r_s1_word;
    logic        r_out_vld;
    logic [63:0] r_out_word;
    logic [1:0]  r_out_status;
    logic [5:0]  r_out_syn;
    logic [2:0]  r_out_par;
    logic        w_out_adv;
    logic        w_s1_adv;

    hsc_cfg #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    hsc_core u_core (
        .i_func   (r_s1_func),
        .i_word   (r_s1_word),
        .i_geom   (w_geom),
        .o_result (w_result)
    );

    assign w_out_adv  = !r_out_vld || !i_out_stall;
    assign w_s1_adv   = !r_s1_vld || w_out_adv;
    assign o_in_stall = !w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_in_valid) begin
            r_s1_func <= i_func;
            r_s1_word <= i_word_in;
        end
        if (w_out_adv && r_s1_vld) begin
            r_out_word   <= w_result.word;
            r_out_status <= w_result.status;
            r_out_syn    <= w_result.syn;
            r_out_par    <= w_geom.r;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_word_out       = r_out_word;
    assign o_status         = r_out_status;
    assign o_error_position = r_out_syn;
    assign o_parity_count   = r_out_par;

    a_clean_no_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hsc_pkg::STAT_CLEAN) |-> (o_error_position == 6'd0))
        else $error("clean result carries a nonzero syndrome");

    a_err_has_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != hsc_pkg::STAT_CLEAN) |-> (o_error_position != 6'd0))
        else $error("error status without a syndrome");

    a_range_beyond_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hsc_pkg::STAT_RANGE) |-> (o_error_position > w_geom.n))
        else $error("out-of-range status for a syndrome inside the codeword");

endmodule

@@ hdl/hsc_cfg.sv @@
`timescale 1ns / 1ps

module hsc_cfg #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output hsc_pkg::t_geom     o_geom
);

    logic [hsc_pkg::POS_W-1:0] r_data_len;
    logic [hsc_pkg::POS_W-1:0] w_d;
    logic                      w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == hsc_pkg::REG_DATA_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len <= 6'd4;
        end else if (w_wr) begin
            r_data_len <= pwdata[hsc_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == hsc_pkg::REG_DATA_LEN) begin
            prdata = {26'd0, r_data_len};
        end else begin
            prdata = 32'd0;
        end
    end

    // A length of zero acts as one; anything above the maximum is clamped.
    always_comb begin
        if (r_data_len == 6'd0) begin
            w_d = 6'd1;
        end else if (r_data_len > 6'(MAX_DATA_BITS)) begin
            w_d = 6'(MAX_DATA_BITS);
        end else begin
            w_d = r_data_len;
        end
    end

    assign o_geom.d = w_d;
    assign o_geom.r = hsc_pkg::parity_count(w_d);
    assign o_geom.n = w_d + 6'(hsc_pkg::parity_count(w_d));

endmodule

@@ hdl/hsc_core.sv @@
`timescale 1ns / 1ps

module hsc_core (
    input  logic                        i_func,
    input  logic [hsc_pkg::WORD_W-1:0]  i_word,
    input  hsc_pkg::t_geom              i_geom,
    output hsc_pkg::t_result            o_result
);

    // XOR of the 1-based positions of all set bits among the low 63 bits.
    function automatic logic [hsc_pkg::POS_W-1:0] pos_xor(input logic [63:0] w);
        logic [hsc_pkg::POS_W-1:0] s;
        s = '0;
        for (int p = 1; p < 64; p++) begin
            if (w[p-1]) begin
                s = s ^ 6'(p);
            end
        end
        return s;
    endfunction

    logic [63:0] w_dmask;
    logic [63:0] w_nmask;
    logic [63:0] w_enc;
    logic [63:0] w_dec;
    logic [63:0] w_cw;
    logic [63:0] w_din;
    logic [5:0]  w_enc_syn;
    logic [5:0]  w_dec_syn;
    logic [1:0]  w_status;

    assign w_dmask = (64'd1 << i_geom.d) - 64'd1;
    assign w_nmask = (64'd1 << i_geom.n) - 64'd1;
    assign w_din   = i_word & w_dmask;

    // Encode: scatter data bits to the non-power-of-two positions, then fill parity.
    always_comb begin
        int k;
        k     = 0;
        w_enc = '0;
        for (int p = 1; p < 64; p++) begin
            if ((p & (p - 1)) != 0) begin
                w_enc[p-1] = w_din[k];
                k++;
            end
        end
        w_enc_syn = pos_xor(w_enc);
        for (int j = 0; j < hsc_pkg::POS_W; j++) begin
            w_enc[(1 << j) - 1] = w_enc_syn[j];
        end
    end

    // Decode: syndrome, correct one bit if it lies inside the codeword, gather data.
    always_comb begin
        int k;
        w_cw      = i_word & w_nmask;
        w_dec_syn = pos_xor(w_cw);
        w_status  = hsc_pkg::STAT_CLEAN;
        if (w_dec_syn != 6'd0) begin
            if (w_dec_syn <= i_geom.n) begin
                w_cw     = w_cw ^ (64'd1 << (w_dec_syn - 6'd1));
                w_status = hsc_pkg::STAT_CORRECTED;
            end else begin
                w_status = hsc_pkg::STAT_RANGE;
            end
        end
        k     = 0;
        w_dec = '0;
        for (int p = 1; p < 64; p++) begin
            if ((p & (p - 1)) != 0) begin
                w_dec[k] = w_cw[p-1];
                k++;
            end
        end
    end

    always_comb begin
        if (i_func == hsc_pkg::FUNC_DECODE) begin
            o_result.word   = w_dec;
            o_result.status = w_status;
            o_result.syn    = w_dec_syn;
        end else begin
            o_result.word   = w_enc;
            o_result.status = hsc_pkg::STAT_CLEAN;
            o_result.syn    = 6'd0;
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_BITS  = 57;
    localparam int RUN_LIMIT = 200000;
    localparam int SEG_ITEMS = 142;

    typedef struct packed {
        logic [hsc_pkg::WORD_W-1:0] word;
        logic [1:0]                 status;
        logic [hsc_pkg::POS_W-1:0]  pos;
        logic [hsc_pkg::PAR_W-1:0]  r;
    } t_codec_out;

    typedef struct packed {
        logic [hsc_pkg::POS_W-1:0]  len;
        logic                       func;
        logic [hsc_pkg::WORD_W-1:0] word;
        logic                       typed;
        t_codec_out                 want;
    } t_plan_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_func = 1'b0;
    logic [hsc_pkg::WORD_W-1:0] i_word_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [hsc_pkg::WORD_W-1:0] o_word_out;
    logic [1:0]                 o_status;
    logic [hsc_pkg::POS_W-1:0]  o_error_position;
    logic [hsc_pkg::PAR_W-1:0]  o_parity_count;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [2:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    t_codec_out                results_due[$];
    t_plan_row                 directed_plan[$];
    logic [hsc_pkg::POS_W-1:0] cur_len = 6'd4;
    int unsigned               gap_pct = 27;
    int unsigned               stall_pct = 55;
    logic                      calm = 1'b0;
    int unsigned               mismatches = 0;
    int unsigned               cycles = 0;

    hamming_sec_codec #(
        .MAX_DATA_BITS(MAX_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_word_in(i_word_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_word_out(o_word_out),
        .o_status(o_status),
        .o_error_position(o_error_position),
        .o_parity_count(o_parity_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!calm && $urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int unsigned clamp_len(input logic [hsc_pkg::POS_W-1:0] len);
        int unsigned d;
        d = len;
        if (d < 1) d = 1;
        if (d > MAX_BITS) d = MAX_BITS;
        return d;
    endfunction

    function automatic int unsigned parity_needed(input int unsigned d);
        int unsigned r;
        r = 1;
        while (((1 << r) - r) < d + 1 && r < 7) r++;
        return r;
    endfunction

    function automatic t_codec_out predict_codec(input logic f,
                                                 input logic [hsc_pkg::WORD_W-1:0] w,
                                                 input logic [hsc_pkg::POS_W-1:0] len);
        t_codec_out                 res;
        logic [hsc_pkg::WORD_W-1:0] cw;
        int unsigned                d, r, n, k, syn;
        res = '0;
        d = clamp_len(len);
        r = parity_needed(d);
        n = d + r;
        syn = 0;
        k = 0;
        if (f == hsc_pkg::FUNC_ENCODE) begin
            // Data fill the positions that are not powers of two, in order.
            for (int unsigned p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    res.word[p-1] = w[k];
                    k++;
                end
            end
            for (int unsigned p = 1; p <= n; p++) begin
                if (res.word[p-1]) syn ^= p;
            end
            for (int unsigned b = 0; b < r; b++) begin
                if (((syn >> b) & 1) != 0) res.word[(1 << b) - 1] = 1'b1;
            end
            syn = 0;
        end else begin
            cw = w;
            for (int unsigned p = 1; p <= n; p++) begin
                if (w[p-1]) syn ^= p;
            end
            if (syn != 0) begin
                if (syn <= n) begin
                    cw[syn-1] = ~cw[syn-1];
                    res.status = hsc_pkg::STAT_CORRECTED;
                end else begin
                    res.status = hsc_pkg::STAT_RANGE;
                end
            end
            for (int unsigned p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    res.word[k] = cw[p-1];
                    k++;
                end
            end
        end
        res.pos = syn[hsc_pkg::POS_W-1:0];
        res.r = r[hsc_pkg::PAR_W-1:0];
        return res;
    endfunction

    task automatic add_row(input logic [hsc_pkg::POS_W-1:0] len, input logic f,
                           input logic [hsc_pkg::WORD_W-1:0] w, input logic typed,
                           input logic [hsc_pkg::WORD_W-1:0] want_word,
                           input logic [1:0] want_status,
                           input logic [hsc_pkg::POS_W-1:0] want_pos,
                           input logic [hsc_pkg::PAR_W-1:0] want_r);
        t_plan_row row;
        row.len = len;
        row.func = f;
        row.word = w;
        row.typed = typed;
        row.want.word = want_word;
        row.want.status = want_status;
        row.want.pos = want_pos;
        row.want.r = want_r;
        directed_plan.push_back(row);
    endtask

    task automatic send_request(input logic f, input logic [hsc_pkg::WORD_W-1:0] w,
                                input logic typed, input t_codec_out want);
        while (!calm && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_word_in <= w;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (typed) begin
            results_due.push_back(want);
        end else begin
            results_due.push_back(predict_codec(f, w, cur_len));
        end
    endtask

    // The register may only change with no request in flight.
    task automatic settle_pipeline();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_data_len(input logic [hsc_pkg::POS_W-1:0] len);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {hsc_pkg::REG_DATA_LEN, 2'b00};
        pwdata <= {26'($urandom), len};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_len = len;
    endtask

    always @(posedge i_clk) begin : check_results
        t_codec_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got word_out %h",
                         $time, o_word_out);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (o_word_out !== want.word) begin
                    $display("%0t: word_out expected %h, got %h", $time, want.word, o_word_out);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, o_status);
                    mismatches++;
                end
                if (o_error_position !== want.pos) begin
                    $display("%0t: error_position expected %0d, got %0d", $time, want.pos,
                             o_error_position);
                    mismatches++;
                end
                if (o_parity_count !== want.r) begin
                    $display("%0t: parity_count expected %0d, got %0d", $time, want.r,
                             o_parity_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [hsc_pkg::WORD_W-1:0] w;
        t_codec_out                 enc;
        logic                       f;
        logic [hsc_pkg::POS_W-1:0]  seg_len;
        int unsigned                n, pick, flip;

        // len, func, word, typed, word_out, status, error_position, parity_count
        add_row(6'd4,  hsc_pkg::FUNC_ENCODE, 64'h0, 1'b1, 64'h0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_ENCODE, 64'hF, 1'b1, 64'h7F, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_ENCODE, '1, 1'b1, 64'h7F, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_DECODE, 64'h7F, 1'b1, 64'hF, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_DECODE, 64'h1, 1'b1, 64'h0, hsc_pkg::STAT_CORRECTED,
                6'd1, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_DECODE, 64'h40, 1'b1, 64'h0, hsc_pkg::STAT_CORRECTED,
                6'd7, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 64'h0,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd3);
        add_row(6'd4,  hsc_pkg::FUNC_DECODE, 64'h2D, 1'b0, '0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd0);
        add_row(6'd5,  hsc_pkg::FUNC_DECODE, 64'h104, 1'b1, 64'h11, hsc_pkg::STAT_RANGE,
                6'd10, 3'd4);
        add_row(6'd5,  hsc_pkg::FUNC_ENCODE, 64'h15, 1'b0, '0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd0);
        add_row(6'd0,  hsc_pkg::FUNC_ENCODE, '1, 1'b1, 64'h7, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd2);
        add_row(6'd0,  hsc_pkg::FUNC_DECODE, 64'h7, 1'b1, 64'h1, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd2);
        add_row(6'd0,  hsc_pkg::FUNC_DECODE, 64'h4, 1'b1, 64'h0, hsc_pkg::STAT_CORRECTED,
                6'd3, 3'd2);
        add_row(6'd1,  hsc_pkg::FUNC_DECODE, 64'h2, 1'b0, '0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd0);
        add_row(6'd57, hsc_pkg::FUNC_ENCODE, '1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd6);
        add_row(6'd57, hsc_pkg::FUNC_DECODE, '1, 1'b1, 64'h01FF_FFFF_FFFF_FFFF,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd6);
        add_row(6'd57, hsc_pkg::FUNC_DECODE, 64'h4000_0000_0000_0000, 1'b1, 64'h0,
                hsc_pkg::STAT_CORRECTED, 6'd63, 3'd6);
        add_row(6'd57, hsc_pkg::FUNC_ENCODE, 64'h0123_4567_89AB_CDEF, 1'b0, '0,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd0);
        add_row(6'd63, hsc_pkg::FUNC_ENCODE, '1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd6);
        add_row(6'd63, hsc_pkg::FUNC_DECODE, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, '0,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd0);
        add_row(6'd26, hsc_pkg::FUNC_ENCODE, 64'h03A5_5A3C, 1'b0, '0,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd0);
        add_row(6'd27, hsc_pkg::FUNC_DECODE, 64'h0000_7E1F_C3A0_9B11, 1'b0, '0,
                hsc_pkg::STAT_CLEAN, 6'd0, 3'd0);
        add_row(6'd12, hsc_pkg::FUNC_DECODE, 64'h1FFF, 1'b0, '0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd0);
        add_row(6'd11, hsc_pkg::FUNC_ENCODE, 64'h7FF, 1'b0, '0, hsc_pkg::STAT_CLEAN,
                6'd0, 3'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].len != cur_len) begin
                i_in_valid <= 1'b0;
                settle_pipeline();
                write_data_len(directed_plan[i].len);
            end
            send_request(directed_plan[i].func, directed_plan[i].word, directed_plan[i].typed,
                         directed_plan[i].want);
        end

        for (int seg = 0; seg < 12; seg++) begin
            i_in_valid <= 1'b0;
            settle_pipeline();
            case (seg / 4)
                0: begin
                    gap_pct = 27;
                    stall_pct = 55;
                end
                1: begin
                    gap_pct = 55;
                    stall_pct = 27;
                end
                default: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            case (seg)
                0: seg_len = 6'd57;
                1: seg_len = 6'd1;
                2: seg_len = 6'd0;
                3: seg_len = 6'd5;
                4: seg_len = 6'd63;
                5: seg_len = 6'd11;
                6: seg_len = 6'd12;
                7: seg_len = 6'd4;
                8: seg_len = 6'd26;
                9: seg_len = 6'd27;
                default: seg_len = 6'($urandom);
            endcase
            write_data_len(seg_len);
            n = clamp_len(cur_len) + parity_needed(clamp_len(cur_len));
            for (int item = 0; item < SEG_ITEMS; item++) begin
                if (item % 40 == 0) calm = ($urandom_range(3) == 0);
                w = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 25) begin
                    f = hsc_pkg::FUNC_ENCODE;
                end else begin
                    f = hsc_pkg::FUNC_DECODE;
                    if (pick < 85) begin
                        // A real codeword with junk above its length, then
                        // none, one or two flipped positions.
                        enc = predict_codec(hsc_pkg::FUNC_ENCODE, w, cur_len);
                        w = enc.word | ({$urandom, $urandom} << n);
                        if (pick >= 45) begin
                            flip = $urandom_range(n, 1);
                            w[flip-1] = ~w[flip-1];
                        end
                        if (pick >= 75) begin
                            flip = $urandom_range(n, 1);
                            w[flip-1] = ~w[flip-1];
                        end
                    end
                end
                send_request(f, w, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        calm = 1'b1;
        settle_pipeline();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
